>>> design/lapsh_pkg.sv
// Shared types and constants for the 3x3 Laplacian sharpening core.
// Used by lapsh_line_store, lapsh_kernel and laplacian_sharpen_3x3_core.
package lapsh_pkg;

	// Frame limits
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;

	// Field and counter widths
	localparam int PIX_W     = 8;
	localparam int WIDTH_W   = 12;                  // frame_width register
	localparam int HEIGHT_W  = 13;                  // frame_height register
	localparam int COL_W     = $clog2(MAX_WIDTH);   // column counters, line store address
	localparam int IN_ROW_W  = HEIGHT_W;            // input row must reach frame_height
	localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);  // output row stays below frame_height
	localparam int SUM_W     = 11;                  // up to 8 * 255
	localparam int CFG_W     = 13;                  // widest register
	localparam int CFG_IDX_W = 2;
	localparam int LS_DATA_W = 2 * PIX_W;           // {upper, middle} per column

	// Register reset values
	localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = HEIGHT_W'(480);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = 2'd2;

	// Input item kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// Kernel modes
	localparam logic MODE_EIGHT = 1'b0;
	localparam logic MODE_FOUR  = 1'b1;

	// Output clamp
	localparam int PIX_MAX = 255;

	typedef logic [PIX_W-1:0] pix_t;

	// 3x3 window, index = row * 3 + column, row 0 is the oldest line
	typedef pix_t [8:0] win_t;

	// Which neighbours lie inside the frame
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} border_t;

	// Control carried with a pushed item
	typedef struct packed {
		border_t border;
		logic    emit;
		logic    row_end;
		logic    frame_end;
	} s1_ctl_t;

endpackage

>>> design/lapsh_line_store.sv
// Two line stores packed into one synchronous RAM: each column holds {upper, middle}.
// One write and one registered read per cycle, with a bypass for same-column access.
// Depends on lapsh_pkg.
module lapsh_line_store (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [lapsh_pkg::COL_W-1:0]    rd_addr,
	input  logic                           wr_en,
	input  logic [lapsh_pkg::COL_W-1:0]    wr_addr,
	input  logic [lapsh_pkg::LS_DATA_W-1:0] wr_data,
	output logic [lapsh_pkg::LS_DATA_W-1:0] rd_data
);
	import lapsh_pkg::*;

	logic [LS_DATA_W-1:0] mem [MAX_WIDTH];
	logic [LS_DATA_W-1:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port; a write to the same column in the same cycle is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

>>> design/lapsh_kernel.sv
// Sharpening arithmetic: neighbour sum with border substitution (registered),
// then center gain minus sum and clamp to 0..255. Depends on lapsh_pkg.
module lapsh_kernel (
	input  logic               clk,
	input  logic               en,
	input  logic               mode,
	input  lapsh_pkg::win_t    window,
	input  lapsh_pkg::border_t border,
	output lapsh_pkg::pix_t    pix
);
	import lapsh_pkg::*;

	logic [SUM_W-1:0] sum_c;
	logic [SUM_W-1:0] sum_s2;
	pix_t             center_s2;
	logic [11:0]      gain_c;
	logic signed [13:0] diff_c;

	// neighbour sum; cells outside the frame take the center value
	always_comb begin
		logic ok;
		logic use_cell;
		sum_c = '0;
		for (int r = 0; r < 3; r++) begin
			for (int d = 0; d < 3; d++) begin
				use_cell = !(r == 1 && d == 1) && !(mode == MODE_FOUR && r != 1 && d != 1);
				ok = !((r == 0) && !border.top) && !((r == 2) && !border.bottom) &&
				     !((d == 0) && !border.left) && !((d == 2) && !border.right);
				if (use_cell) begin
					sum_c = sum_c + SUM_W'(ok ? window[r * 3 + d] : window[4]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2    <= sum_c;
			center_s2 <= window[4];
		end
	end

	// gain * center - sum, clamped
	always_comb begin
		gain_c = (mode == MODE_FOUR) ? (12'(center_s2) * 12'd5) : (12'(center_s2) * 12'd9);
		diff_c = $signed({2'b00, gain_c}) - $signed({3'b000, sum_s2});
		if (diff_c < 0) begin
			pix = '0;
		end else if (diff_c > 14'sd255) begin
			pix = PIX_W'(PIX_MAX);
		end else begin
			pix = diff_c[PIX_W-1:0];
		end
	end

endmodule

>>> design/laplacian_sharpen_3x3_core.sv
// Top level of the 3x3 Laplacian sharpening core.
// Depends on lapsh_pkg, lapsh_line_store and lapsh_kernel.
//
// Usage:
//   Input channel (in_valid / in_stall): kind selects a pixel or a drain step;
//   pixels come in raster order. After a frame's last pixel, drain steps push
//   the pending outputs (the last row plus one pixel) out of the window.
//   Output channel (out_valid / out_stall): one sharpened pixel per transfer,
//   with row_end and frame_end marking row and frame boundaries.
//   Configuration: cfg_wr_en writes frame_width, frame_height or kernel_mode
//   at cfg_index; a width or height write restarts the frame. Write only idle.
// Timing:
//   One item per clock sustained while the output is not stalled. A result
//   reaches the output register after the transfer of the item that releases it
//   (line store read and window shift, then neighbour sum, then clamp into the output register).
//   The first output of a frame needs frame_width + 2 pixels in.
// Reset: counters clear, registers return to 640 x 480, four-neighbour mode.
//   The line store RAM is not cleared; cells outside the frame are replaced.
// Stall: the output register holds its result; two more items fill the
//   pipeline, then in_stall rises until the receiver takes a transfer.
module laplacian_sharpen_3x3_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  lapsh_pkg::pix_t                   pixel_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output lapsh_pkg::pix_t                   pixel_out,
	output logic                              row_end,
	output logic                              frame_end,
	input  logic                              cfg_wr_en,
	input  logic [lapsh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lapsh_pkg::CFG_W-1:0]       cfg_data
);
	import lapsh_pkg::*;

	// configuration
	logic [WIDTH_W-1:0]  frame_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;
	logic                kernel_mode_q;
	logic [WIDTH_W-1:0]  width_clamp;
	logic [HEIGHT_W-1:0] height_clamp;
	logic                restart;

	// frame counters
	logic [COL_W-1:0]     in_column_q;
	logic [IN_ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]     out_column_q;
	logic [OUT_ROW_W-1:0] out_row_q;

	// accept stage
	logic    complete;
	logic    push;
	logic    acc;
	logic    acc_push;
	logic    in_col_last;
	logic    oc_last;
	logic    or_last;
	s1_ctl_t ctl_c;

	// stage 1
	logic             v_s1;
	pix_t             p_s1;
	logic [COL_W-1:0] addr_s1;
	s1_ctl_t          ctl_s1;
	logic [LS_DATA_W-1:0] ls_rd;
	pix_t             up;
	pix_t             mid;
	win_t             win_q;
	win_t             new_win;

	// stage 2 and output
	logic v_s2;
	logic row_end_s2;
	logic frame_end_s2;
	pix_t kern_pix;
	logic out_valid_q;
	pix_t pixel_out_q;
	logic row_end_q;
	logic frame_end_q;

	logic adv_s1;
	logic adv_s2;
	logic load_out;
	logic leave_s1;

	// pipeline flow
	assign load_out = v_s2 && (!out_valid_q || !out_stall);
	assign adv_s2   = !v_s2 || load_out;
	assign adv_s1   = !v_s1 || adv_s2;
	assign leave_s1 = v_s1 && adv_s2;
	assign in_stall = !adv_s1;
	assign acc      = in_valid && !in_stall;

	// configuration value clamping
	always_comb begin
		width_clamp = cfg_data[WIDTH_W-1:0];
		if (width_clamp == '0) begin
			width_clamp = WIDTH_W'(1);
		end else if (width_clamp > WIDTH_W'(MAX_WIDTH)) begin
			width_clamp = WIDTH_W'(MAX_WIDTH);
		end
		height_clamp = cfg_data[HEIGHT_W-1:0];
		if (height_clamp == '0) begin
			height_clamp = HEIGHT_W'(1);
		end else if (height_clamp > HEIGHT_W'(MAX_HEIGHT)) begin
			height_clamp = HEIGHT_W'(MAX_HEIGHT);
		end
	end

	assign restart = cfg_wr_en && ((cfg_index == CFG_FRAME_WIDTH) ||
	                               (cfg_index == CFG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			kernel_mode_q  <= MODE_FOUR;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= width_clamp;
				CFG_FRAME_HEIGHT: frame_height_q <= height_clamp;
				CFG_KERNEL_MODE:  kernel_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// accept stage decode
	always_comb begin
		complete    = in_row_q >= IN_ROW_W'(frame_height_q);
		push        = complete || (kind == KIND_PIXEL);
		acc_push    = acc && push;
		in_col_last = (WIDTH_W'(in_column_q) + WIDTH_W'(1)) >= frame_width_q;
		oc_last     = (WIDTH_W'(out_column_q) + WIDTH_W'(1)) >= frame_width_q;
		or_last     = (HEIGHT_W'(out_row_q) + HEIGHT_W'(1)) >= frame_height_q;

		ctl_c.border.top    = out_row_q != '0;
		ctl_c.border.bottom = !or_last;
		ctl_c.border.left   = out_column_q != '0;
		ctl_c.border.right  = !oc_last;
		ctl_c.row_end       = oc_last;
		ctl_c.frame_end     = oc_last && or_last;
		// no output until the window center has reached the first pixel
		ctl_c.emit = !((in_row_q == '0) ||
		               ((in_row_q == IN_ROW_W'(1)) && (in_column_q == '0)));
	end

	// frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q  <= '0;
			in_row_q     <= '0;
			out_column_q <= '0;
			out_row_q    <= '0;
		end else if (restart) begin
			in_column_q  <= '0;
			in_row_q     <= '0;
			out_column_q <= '0;
			out_row_q    <= '0;
		end else if (acc_push) begin
			if (ctl_c.emit && ctl_c.frame_end) begin
				in_column_q  <= '0;
				in_row_q     <= '0;
				out_column_q <= '0;
				out_row_q    <= '0;
			end else begin
				if (in_col_last) begin
					in_column_q <= '0;
					if (in_row_q != '1) begin
						in_row_q <= in_row_q + IN_ROW_W'(1);
					end
				end else begin
					in_column_q <= in_column_q + COL_W'(1);
				end
				if (ctl_c.emit) begin
					if (ctl_c.row_end) begin
						out_column_q <= '0;
						out_row_q    <= out_row_q + OUT_ROW_W'(1);
					end else begin
						out_column_q <= out_column_q + COL_W'(1);
					end
				end
			end
		end
	end

	// line store read at accept, write back as the item leaves stage 1
	lapsh_line_store u_line_store (
		.clk     (clk),
		.rd_en   (acc_push),
		.rd_addr (in_column_q),
		.wr_en   (leave_s1),
		.wr_addr (addr_s1),
		.wr_data ({mid, p_s1}),
		.rd_data (ls_rd)
	);

	assign up  = ls_rd[LS_DATA_W-1:PIX_W];
	assign mid = ls_rd[PIX_W-1:0];

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= acc_push;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_push) begin
			p_s1    <= complete ? '0 : pixel_in;
			addr_s1 <= in_column_q;
			ctl_s1  <= ctl_c;
		end
	end

	// window shift: each row moves left, new column from the line stores
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			new_win[r * 3 + 0] = win_q[r * 3 + 1];
			new_win[r * 3 + 1] = win_q[r * 3 + 2];
		end
		new_win[2] = up;
		new_win[5] = mid;
		new_win[8] = p_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (leave_s1) begin
			win_q <= new_win;
		end
	end

	// sum stage and clamp
	lapsh_kernel u_kernel (
		.clk    (clk),
		.en     (leave_s1 && ctl_s1.emit),
		.mode   (kernel_mode_q),
		.window (new_win),
		.border (ctl_s1.border),
		.pix    (kern_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1 && ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_s1 && ctl_s1.emit) begin
			row_end_s2   <= ctl_s1.row_end;
			frame_end_s2 <= ctl_s1.frame_end;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixel_out_q <= kern_pix;
			row_end_q   <= row_end_s2;
			frame_end_q <= frame_end_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

	// input is held back only when every stage is full and the output waits
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_valid_q && out_stall))
		else $error("in_stall raised with room in the pipeline");

	// a waiting stage 2 result is not dropped while the output is stalled
	a_s2_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && out_valid_q && out_stall) |=> v_s2)
		else $error("stage 2 result lost under stall");

	// input column stays inside the row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		WIDTH_W'(in_column_q) < frame_width_q)
		else $error("input column beyond frame width");

	// frame end only on a row end
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_end_q) |-> row_end_q)
		else $error("frame_end without row_end");

	// output row counter stays inside the frame
	a_out_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		HEIGHT_W'(out_row_q) < frame_height_q)
		else $error("output row beyond frame height");

endmodule

>>> test/laplacian_sharpen_3x3_core_test.sv
// Self-checking testbench for laplacian_sharpen_3x3_core: directed and random frames, both kernels.
// Depends on lapsh_pkg and the core. An inline pixel predictor feeds a queue of due results.
module laplacian_sharpen_3x3_core_test;
	import lapsh_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 1150;
	localparam int unsigned BURST_ITEMS   = 200;      // pixels per size-limit phase
	localparam int unsigned SETTLE_CYCLES = 8;        // wait after the last due pixel
	localparam int unsigned CYCLE_LIMIT   = 1500000;
	localparam int unsigned PRINT_CAP     = 40;

	typedef struct packed {
		logic kind;
		pix_t pix;
	} src_item_t;

	typedef struct packed {
		pix_t pix;
		logic row_end;
		logic frame_end;
	} sharp_t;

	// DUT connections, all inputs known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = KIND_PIXEL;
	pix_t pixel_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pix_t pixel_out;
	logic row_end;
	logic frame_end;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	// Pending source items and sharpened pixels still due
	src_item_t pixel_feed[$];
	sharp_t due_pixels[$];
	src_item_t next_item;
	sharp_t want;

	// Predictor state
	pix_t upper_mem [MAX_WIDTH];
	pix_t middle_mem [MAX_WIDTH];
	pix_t win_pix [9];
	int unsigned src_col, src_row, dst_col, dst_row;
	int unsigned cur_width, cur_height;
	logic cur_mode;

	// Idle control and bookkeeping
	bit calm = 1'b0;
	int unsigned in_idle_pct = 0, out_idle_pct = 0;
	int unsigned in_gap = 0, out_gap = 0;
	int unsigned cycle_count = 0, mismatches = 0, checked = 0;
	int unsigned pixel_xfers = 0, drain_xfers = 0, cfg_writes = 0, frames_queued = 0;
	int unsigned widest = 0, tallest = 0;

	laplacian_sharpen_3x3_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.row_end   (row_end),
		.frame_end (frame_end),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void clear_positions();
		src_col = 0;
		src_row = 0;
		dst_col = 0;
		dst_row = 0;
	endfunction

	function automatic void predictor_reset();
		cur_width = FRAME_WIDTH_RST;
		cur_height = FRAME_HEIGHT_RST;
		cur_mode = MODE_FOUR;
		foreach (upper_mem[i]) begin
			upper_mem[i] = '0;
			middle_mem[i] = '0;
		end
		foreach (win_pix[i])
			win_pix[i] = '0;
		clear_positions();
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		int unsigned v;
		case (idx)
			CFG_FRAME_WIDTH: begin
				v = data[WIDTH_W-1:0];
				cur_width = (v < 1) ? 1 : ((v > MAX_WIDTH) ? MAX_WIDTH : v);
				clear_positions();
			end
			CFG_FRAME_HEIGHT: begin
				v = data[HEIGHT_W-1:0];
				cur_height = (v < 1) ? 1 : ((v > MAX_HEIGHT) ? MAX_HEIGHT : v);
				clear_positions();
			end
			CFG_KERNEL_MODE: cur_mode = data[0];
			default: ;
		endcase
	endfunction

	// One place through both line stores and the window
	function automatic void shift_in(pix_t p);
		pix_t up, mid;
		up = upper_mem[src_col];
		mid = middle_mem[src_col];
		upper_mem[src_col] = mid;
		middle_mem[src_col] = p;
		for (int r = 0; r < 3; r++) begin
			win_pix[r * 3]     = win_pix[r * 3 + 1];
			win_pix[r * 3 + 1] = win_pix[r * 3 + 2];
		end
		win_pix[2] = up;
		win_pix[5] = mid;
		win_pix[8] = p;
		src_col++;
		if (src_col >= cur_width) begin
			src_col = 0;
			src_row++;
		end
	endfunction

	// Kernel on the window centre; neighbours off the frame take the centre value
	function automatic pix_t sharpened();
		int c, sum, v;
		bit top, bottom, left, right, ok;
		c = win_pix[4];
		top = dst_row > 0;
		bottom = dst_row + 1 < cur_height;
		left = dst_col > 0;
		right = dst_col + 1 < cur_width;
		sum = 0;
		for (int r = 0; r < 3; r++) begin
			for (int d = 0; d < 3; d++) begin
				if (r == 1 && d == 1)
					continue;
				if (cur_mode == MODE_FOUR && r != 1 && d != 1)
					continue;
				ok = !((r == 0 && !top) || (r == 2 && !bottom) ||
					(d == 0 && !left) || (d == 2 && !right));
				sum += ok ? int'(win_pix[r * 3 + d]) : c;
			end
		end
		v = ((cur_mode == MODE_FOUR) ? 5 : 9) * c - sum;
		if (v < 0)
			v = 0;
		if (v > PIX_MAX)
			v = PIX_MAX;
		return pix_t'(v);
	endfunction

	function automatic void predict_transfer(logic k, pix_t p);
		bit done;
		int unsigned pos;
		sharp_t res;
		done = src_row >= cur_height;
		pos = src_row * cur_width + src_col;
		// pixels past the frame end push empty places like drains
		if (!done && k == KIND_PIXEL)
			shift_in(p);
		else if (done)
			shift_in('0);
		else
			return;
		if (pos < cur_width + 1)
			return;
		res.pix = sharpened();
		res.row_end = dst_col + 1 >= cur_width;
		res.frame_end = res.row_end && (dst_row + 1 >= cur_height);
		due_pixels = {due_pixels, res};
		if (res.frame_end) begin
			clear_positions();
		end else if (res.row_end) begin
			dst_col = 0;
			dst_row++;
		end else begin
			dst_col++;
		end
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic void queue_item(logic k, pix_t p);
		src_item_t it;
		it.kind = k;
		it.pix = p;
		pixel_feed = {pixel_feed, it};
	endfunction

	// One frame of pixels with light noise, then the drain steps that flush it.
	// A cut frame stops early and leaves the rest to the next restart.
	function automatic int unsigned queue_frame(int unsigned w, int unsigned h, bit cut);
		int unsigned total, stop, n, count;
		bit harsh;
		pix_t p;
		total = w * h;
		stop = cut ? $urandom_range(0, total - 1) : total;
		harsh = $urandom_range(0, 3) == 0;
		count = 0;
		if (w > widest)
			widest = w;
		if (h > tallest)
			tallest = h;
		for (n = 0; n < stop; n++) begin
			// drain mid-frame is ignored by the core
			if ($urandom_range(0, 99) < 3)
				queue_item(KIND_DRAIN, pix_t'($urandom));
			if (harsh && $urandom_range(0, 3) != 0)
				p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			else
				p = pix_t'($urandom);
			queue_item(KIND_PIXEL, p);
			count++;
		end
		if (!cut) begin
			for (n = 0; n <= w; n++) begin
				if ($urandom_range(0, 99) < 15)
					queue_item(KIND_PIXEL, pix_t'($urandom));
				else
					queue_item(KIND_DRAIN, pix_t'($urandom));
				count++;
			end
			// spare drains after the frame closed
			n = $urandom_range(0, 7);
			if (n < 2)
				repeat (n + 1) queue_item(KIND_DRAIN, pix_t'($urandom));
		end
		frames_queued++;
		return count;
	endfunction

	// A run of pixels into the current frame that stops well short of its end
	function automatic int unsigned queue_burst(int unsigned n);
		if (cur_width > widest)
			widest = cur_width;
		if (cur_height > tallest)
			tallest = cur_height;
		for (int unsigned i = 0; i < n; i++)
			queue_item(KIND_PIXEL, pix_t'($urandom));
		return n;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		apply_reg(idx, data);
		cfg_writes++;
	endtask

	// Everything sent, every due pixel seen, pipeline given time to settle
	task automatic wait_idle();
		@(negedge clk);
		while (pixel_feed.size() != 0 || in_valid || due_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[cycle %0d] mismatch: %s", cycle_count, msg);
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_transfer(kind, pixel_in);
				if (kind == KIND_PIXEL)
					pixel_xfers++;
				else
					drain_xfers++;
			end
			// slot free: idle out a burst or present the next item
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pixel_feed.size() > 0) begin
					next_item = pixel_feed.pop_front();
					in_valid <= 1'b1;
					kind <= next_item.kind;
					pixel_in <= next_item.pix;
					if (!calm && $urandom_range(0, 99) < in_idle_pct)
						in_gap = $urandom_range(1, 16);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected transfer, pixel %0d", pixel_out));
				end else begin
					want = due_pixels.pop_front();
					checked++;
					if (pixel_out !== want.pix)
						report_mismatch($sformatf("pixel_out %0d, predicted %0d",
							pixel_out, want.pix));
					if (row_end !== want.row_end)
						report_mismatch($sformatf("row_end %b, predicted %b",
							row_end, want.row_end));
					if (frame_end !== want.frame_end)
						report_mismatch($sformatf("frame_end %b, predicted %b",
							frame_end, want.frame_end));
				end
			end
			// receiver stalls in bursts whose length is drawn at random
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
				out_gap = $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("no progress: stopped at %0d cycles, %0d pixels still due",
				cycle_count, due_pixels.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int unsigned random_items, phase_no, w, h, frames;
		predictor_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		in_idle_pct = 20;
		out_idle_pct = 20;

		// Directed: 3x2 frame, eight-neighbour kernel, extreme pixels,
		// drains before and inside the frame, a pixel past the end, a spare drain
		write_reg(CFG_FRAME_WIDTH, 13'd3);
		write_reg(CFG_FRAME_HEIGHT, 13'd2);
		write_reg(CFG_KERNEL_MODE, {12'd0, MODE_EIGHT});
		@(negedge clk);
		queue_item(KIND_DRAIN, 8'd255);
		queue_item(KIND_PIXEL, 8'd0);
		queue_item(KIND_PIXEL, 8'd255);
		queue_item(KIND_PIXEL, 8'd0);
		queue_item(KIND_DRAIN, 8'd0);
		queue_item(KIND_PIXEL, 8'd255);
		queue_item(KIND_PIXEL, 8'd0);
		queue_item(KIND_PIXEL, 8'd255);
		queue_item(KIND_PIXEL, 8'd128);
		repeat (3) queue_item(KIND_DRAIN, 8'd0);
		queue_item(KIND_DRAIN, 8'd0);
		wait_idle();

		// Directed: one-row frame, four-neighbour kernel; first drain releases nothing
		write_reg(CFG_FRAME_WIDTH, 13'd4);
		write_reg(CFG_FRAME_HEIGHT, 13'd1);
		write_reg(CFG_KERNEL_MODE, {12'h800, MODE_FOUR});
		@(negedge clk);
		queue_item(KIND_PIXEL, 8'd255);
		queue_item(KIND_PIXEL, 8'd0);
		queue_item(KIND_PIXEL, 8'd0);
		queue_item(KIND_PIXEL, 8'd255);
		repeat (5) queue_item(KIND_DRAIN, 8'd255);
		wait_idle();

		// Random phases: mostly small frames, two phases at the size limits
		random_items = 0;
		phase_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			calm = random_items > (RANDOM_ITEMS * 4) / 5;
			in_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 30);
			out_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 30);
			if (phase_no == 3) begin
				// width over the limit clamps to the maximum, height 0 becomes 1;
				// the burst stays short of the first output of the wide row
				write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
				write_reg(CFG_FRAME_HEIGHT, 13'h0000);
				write_reg(CFG_KERNEL_MODE, CFG_W'($urandom));
				@(negedge clk);
				random_items += queue_burst(BURST_ITEMS);
			end else if (phase_no == 7) begin
				// width 0 becomes 1, height over the limit clamps to the maximum;
				// one-pixel rows, stopped long before the frame end
				write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
				write_reg(CFG_FRAME_WIDTH, 13'h0000);
				@(negedge clk);
				random_items += queue_burst(BURST_ITEMS);
			end else begin
				w = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 64);
				h = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 10);
				// occasionally keep the old size and carry on from where it stopped
				if (cur_width > 64 || cur_height > 10 || $urandom_range(0, 9) != 0)
					write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
				if (cur_width > 64 || cur_height > 10 || $urandom_range(0, 9) != 0)
					write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
				if ($urandom_range(0, 9) < 6)
					write_reg(CFG_KERNEL_MODE, CFG_W'($urandom));
				@(negedge clk);
				frames = $urandom_range(1, 3);
				for (int f = 0; f < frames; f++)
					random_items += queue_frame(cur_width, cur_height,
						f == frames - 1 && $urandom_range(0, 7) == 0);
			end
			wait_idle();
			phase_no++;
		end

		$display("covered %0d pixel and %0d drain transfers in %0d frames, %0d register writes",
			pixel_xfers, drain_xfers, frames_queued, cfg_writes);
		$display("sizes up to %0d x %0d, %0d sharpened pixels checked, %0d mismatches",
			widest, tallest, checked, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
